FILE: sv/assert_macros.svh
// Assertion macros used by the top level of the vector polar/cartesian unit.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/v2pc_pkg.sv
// Package of the vector polar/cartesian unit: function codes, widths,
// CORDIC constants and the stage payload types. No dependencies.
`timescale 1ns / 1ps

package v2pc_pkg;

    localparam logic [1:0] FN_MAG  = 2'd0;
    localparam logic [1:0] FN_NORM = 2'd1;
    localparam logic [1:0] FN_C2P  = 2'd2;
    localparam logic [1:0] FN_P2C  = 2'd3;

    localparam int CW       = 34;   // CORDIC x/y/z word
    localparam int RW       = 20;   // result word before saturation
    localparam int SQ_W     = 30;   // sum of squares
    localparam int SQ_STEPS = 15;   // root bits
    localparam int MAG_W    = 15;
    localparam int Q_W      = 13;   // normalize quotient bits
    localparam int DIV_W    = 30;   // divider remainder
    localparam int DEN_W    = 16;   // divider denominator (2 * magnitude)

    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cvec_t;

    typedef struct packed {
        logic [1:0]        func;
        logic signed [14:0] a;
        logic signed [14:0] b;
        logic [SQ_W-1:0]   sumsq;
        logic              flip;
    } cside_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [14:0] a;
        logic signed [14:0] b;
        logic signed [RW-1:0] res_a;
        logic signed [RW-1:0] res_b;
    } sside_t;

    // atan(2^-i) in Q30 radians
    function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
        logic signed [CW-1:0] v;
        case (i)
            0: v = 34'sd843314857;
            1: v = 34'sd497837829;
            2: v = 34'sd263043837;
            3: v = 34'sd133525159;
            4: v = 34'sd67021687;
            5: v = 34'sd33543516;
            6: v = 34'sd16775851;
            7: v = 34'sd8388437;
            8: v = 34'sd4194283;
            9: v = 34'sd2097149;
            default: v = (i <= 30) ? (34'sd1 <<< (30 - i)) : '0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/v2pc_cordic.sv
// Unrolled CORDIC pipeline, one micro-rotation per register stage.
// Vectoring or rotation chosen per item by its function code. Uses v2pc_pkg.
`timescale 1ns / 1ps

module v2pc_cordic #(
    parameter int STAGES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  v2pc_pkg::cvec_t  vec_in,
    input  v2pc_pkg::cside_t side_in,
    output logic             valid_out,
    output v2pc_pkg::cvec_t  vec_out,
    output v2pc_pkg::cside_t side_out
);
    import v2pc_pkg::*;

    logic   vld_reg  [STAGES];
    cvec_t  vec_reg  [STAGES];
    cside_t side_reg [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic signed [CW-1:0] AT = atan_q30(k);
        logic   pvld;
        cvec_t  pvec;
        cside_t pside;
        cvec_t  vec_next;
        logic   pos;

        if (k == 0) begin : g_first
            assign pvld  = valid_in;
            assign pvec  = vec_in;
            assign pside = side_in;
        end else begin : g_rest
            assign pvld  = vld_reg[k-1];
            assign pvec  = vec_reg[k-1];
            assign pside = side_reg[k-1];
        end

        // rotation steers on z, vectoring drives y toward zero
        always_comb
        begin
            pos = (pside.func == FN_P2C) ? (pvec.z >= 0) : (pvec.y < 0);
            if (pos)
            begin
                vec_next.x = pvec.x - (pvec.y >>> k);
                vec_next.y = pvec.y + (pvec.x >>> k);
                vec_next.z = pvec.z - AT;
            end
            else
            begin
                vec_next.x = pvec.x + (pvec.y >>> k);
                vec_next.y = pvec.y - (pvec.x >>> k);
                vec_next.z = pvec.z + AT;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= pvld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vec_reg[k]  <= vec_next;
                side_reg[k] <= pside;
            end
        end
    end

    assign valid_out = vld_reg[STAGES-1];
    assign vec_out   = vec_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

FILE: sv/v2pc_sqrt.sv
// Pipelined integer square root, one root bit per stage, then round to nearest.
// Carries a sideband alongside. Uses v2pc_pkg.
`timescale 1ns / 1ps

module v2pc_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       valid_in,
    input  logic [v2pc_pkg::SQ_W-1:0]  n_in,
    input  v2pc_pkg::sside_t           side_in,
    output logic                       valid_out,
    output logic [v2pc_pkg::MAG_W-1:0] mag_out,
    output v2pc_pkg::sside_t           side_out
);
    import v2pc_pkg::*;

    logic            vld_reg  [SQ_STEPS];
    logic [SQ_W-1:0] n_reg    [SQ_STEPS];
    logic [SQ_W:0]   r_reg    [SQ_STEPS];
    sside_t          side_reg [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (2 * (SQ_STEPS - 1 - k));
        logic            pvld;
        logic [SQ_W-1:0] pn;
        logic [SQ_W:0]   pr;
        sside_t          pside;
        logic [SQ_W:0]   t;
        logic            ge;
        logic [SQ_W-1:0] n_next;
        logic [SQ_W:0]   r_next;

        if (k == 0) begin : g_first
            assign pvld  = valid_in;
            assign pn    = n_in;
            assign pr    = '0;
            assign pside = side_in;
        end else begin : g_rest
            assign pvld  = vld_reg[k-1];
            assign pn    = n_reg[k-1];
            assign pr    = r_reg[k-1];
            assign pside = side_reg[k-1];
        end

        always_comb
        begin
            t      = pr + BIT;
            ge     = {1'b0, pn} >= t;
            n_next = ge ? (pn - t[SQ_W-1:0]) : pn;
            r_next = ge ? ((pr >> 1) + BIT) : (pr >> 1);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= pvld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]    <= n_next;
                r_reg[k]    <= r_next;
                side_reg[k] <= pside;
            end
        end
    end

    // round: bump when remainder exceeds root
    logic             vld_out_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [MAG_W-1:0] mag_next;
    sside_t           side_out_reg;

    always_comb
    begin
        mag_next = r_reg[SQ_STEPS-1][MAG_W-1:0];
        if ({1'b0, n_reg[SQ_STEPS-1]} > r_reg[SQ_STEPS-1])
            mag_next = mag_next + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out_reg <= 1'b0;
        else if (en)
            vld_out_reg <= vld_reg[SQ_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg      <= mag_next;
            side_out_reg <= side_reg[SQ_STEPS-1];
        end
    end

    assign valid_out = vld_out_reg;
    assign mag_out   = mag_reg;
    assign side_out  = side_out_reg;

endmodule

FILE: sv/vector2_polar_cartesian_unit.sv
// Top level of the 2D vector function unit: magnitude, normalize, and
// cartesian/polar conversion in Q3.12. Uses v2pc_pkg, v2pc_cordic, v2pc_sqrt.
`timescale 1ns / 1ps
//
//  channel | signals                              | dir | meaning
//  --------+--------------------------------------+-----+---------------------------
//  in      | in_valid in_ready func in_a in_b     | in  | one operation request
//  out     | out_valid out_ready out_a out_b      | out | one result per request
//
//  One request accepted per cycle while in_ready is high; the register chain is
//  front(3) + CORDIC(CORDIC_STAGES) + post(1) + root(16) + divide prep(1) +
//  divide(13) + output(1).
//  All stages advance on one enable that is high whenever the output register
//  is empty or being taken; a stall freezes every stage together.
//  Reset clears only the valid bits; the pipeline is empty after reset.

module vector2_polar_cartesian_unit #(
    parameter int DATA_WIDTH    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic signed [14:0] in_a,
    input  logic signed [14:0] in_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_a,
    output logic signed [15:0] out_b
);
    import v2pc_pkg::*;

`include "assert_macros.svh"

    localparam logic signed [CW-1:0] SAT_HI = 34'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - 34'sd1;
    localparam logic signed [45:0]   GAIN46 = 46'(GAIN_Q30);

    typedef struct packed {
        logic [1:0]           func;
        logic                 neg_a;
        logic                 neg_b;
        logic                 zero_a;
        logic                 zero_b;
        logic [MAG_W-1:0]     mag;
        logic signed [RW-1:0] res_a;
        logic signed [RW-1:0] res_b;
        logic [DIV_W-1:0]     rem_a;
        logic [DIV_W-1:0]     rem_b;
        logic [DEN_W-1:0]     den;
        logic [Q_W-1:0]       q_a;
        logic [Q_W-1:0]       q_b;
    } dstage_t;

    // global advance: output empty or being taken
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // ---------------- stage 1: capture request
    logic               s1_vld_reg;
    logic [1:0]         s1_func_reg;
    logic signed [14:0] s1_a_reg;
    logic signed [14:0] s1_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_func_reg <= func;
            s1_a_reg    <= in_a;
            s1_b_reg    <= in_b;
        end
    end

    // ---------------- stage 2: squares, gain product, quadrant setup
    logic signed [29:0]   a30, b30, sqa_full, sqb_full;
    logic signed [45:0]   b46, gprod_next;
    logic signed [CW-1:0] ax, by;
    cvec_t                vvec_next;
    logic signed [CW-1:0] rz_next;
    logic                 flip_next;

    always_comb
    begin
        a30        = 30'(s1_a_reg);
        b30        = 30'(s1_b_reg);
        sqa_full   = a30 * a30;
        sqb_full   = b30 * b30;
        b46        = 46'(s1_b_reg);
        gprod_next = b46 * GAIN46;
        ax         = 34'(s1_a_reg) <<< 16;
        by         = 34'(s1_b_reg) <<< 16;
        // left half plane: pre-rotate by a quarter turn
        if (s1_a_reg < 0)
        begin
            if (s1_b_reg >= 0)
            begin
                vvec_next.x = by;
                vvec_next.y = -ax;
                vvec_next.z = HALF_PI_Q30;
            end
            else
            begin
                vvec_next.x = -by;
                vvec_next.y = ax;
                vvec_next.z = -HALF_PI_Q30;
            end
        end
        else
        begin
            vvec_next.x = ax;
            vvec_next.y = by;
            vvec_next.z = '0;
        end
        // polar angle folded into +-pi/2, result negated later
        rz_next   = 34'(s1_a_reg) <<< 18;
        flip_next = 1'b0;
        if (rz_next > HALF_PI_Q30)
        begin
            rz_next   = rz_next - PI_Q30;
            flip_next = 1'b1;
        end
        else if (rz_next < -HALF_PI_Q30)
        begin
            rz_next   = rz_next + PI_Q30;
            flip_next = 1'b1;
        end
    end

    logic                 s2_vld_reg;
    logic [1:0]           s2_func_reg;
    logic signed [14:0]   s2_a_reg;
    logic signed [14:0]   s2_b_reg;
    logic [28:0]          s2_sqa_reg;
    logic [28:0]          s2_sqb_reg;
    logic signed [45:0]   s2_gprod_reg;
    cvec_t                s2_vvec_reg;
    logic signed [CW-1:0] s2_rz_reg;
    logic                 s2_flip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (en)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_func_reg  <= s1_func_reg;
            s2_a_reg     <= s1_a_reg;
            s2_b_reg     <= s1_b_reg;
            s2_sqa_reg   <= sqa_full[28:0];
            s2_sqb_reg   <= sqb_full[28:0];
            s2_gprod_reg <= gprod_next;
            s2_vvec_reg  <= vvec_next;
            s2_rz_reg    <= rz_next;
            s2_flip_reg  <= flip_next;
        end
    end

    // ---------------- stage 3: sum of squares, rounded gain, CORDIC seed
    logic signed [45:0] gp_rnd;
    cvec_t              cvec_next;
    cside_t             cside_next;

    always_comb
    begin
        gp_rnd = (s2_gprod_reg + 46'sd8192) >>> 14;
        if (s2_func_reg == FN_P2C)
        begin
            cvec_next.x = gp_rnd[CW-1:0];
            cvec_next.y = '0;
            cvec_next.z = s2_rz_reg;
        end
        else
            cvec_next = s2_vvec_reg;
        cside_next.func  = s2_func_reg;
        cside_next.a     = s2_a_reg;
        cside_next.b     = s2_b_reg;
        cside_next.sumsq = SQ_W'(s2_sqa_reg) + SQ_W'(s2_sqb_reg);
        cside_next.flip  = s2_flip_reg;
    end

    logic   s3_vld_reg;
    cvec_t  s3_vec_reg;
    cside_t s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (en)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_vec_reg  <= cvec_next;
            s3_side_reg <= cside_next;
        end
    end

    // ---------------- CORDIC
    logic   cd_vld;
    cvec_t  cd_vec;
    cside_t cd_side;

    v2pc_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (s3_vld_reg),
        .vec_in    (s3_vec_reg),
        .side_in   (s3_side_reg),
        .valid_out (cd_vld),
        .vec_out   (cd_vec),
        .side_out  (cd_side)
    );

    // ---------------- post: round angle / coordinates, undo fold
    logic signed [CW-1:0] z_rnd, x_rnd, y_rnd;
    logic signed [RW-1:0] ang, rx, ry;
    sside_t               sside_next;

    always_comb
    begin
        z_rnd = (cd_vec.z + 34'sd131072) >>> 18;
        x_rnd = (cd_vec.x + 34'sd32768) >>> 16;
        y_rnd = (cd_vec.y + 34'sd32768) >>> 16;
        ang   = (cd_side.a == 0 && cd_side.b == 0) ? '0 : z_rnd[RW-1:0];
        rx    = cd_side.flip ? -x_rnd[RW-1:0] : x_rnd[RW-1:0];
        ry    = cd_side.flip ? -y_rnd[RW-1:0] : y_rnd[RW-1:0];
        sside_next.func  = cd_side.func;
        sside_next.a     = cd_side.a;
        sside_next.b     = cd_side.b;
        sside_next.res_a = (cd_side.func == FN_P2C) ? rx : ang;
        sside_next.res_b = ry;
    end

    logic            pt_vld_reg;
    sside_t          pt_side_reg;
    logic [SQ_W-1:0] pt_sumsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pt_vld_reg <= 1'b0;
        else if (en)
            pt_vld_reg <= cd_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_side_reg  <= sside_next;
            pt_sumsq_reg <= cd_side.sumsq;
        end
    end

    // ---------------- magnitude
    logic             sq_vld;
    logic [MAG_W-1:0] sq_mag;
    sside_t           sq_side;

    v2pc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (pt_vld_reg),
        .n_in      (pt_sumsq_reg),
        .side_in   (pt_side_reg),
        .valid_out (sq_vld),
        .mag_out   (sq_mag),
        .side_out  (sq_side)
    );

    // ---------------- divide prep: |c| * 8192 + mag over 2 * mag
    logic [14:0] abs_a, abs_b;
    dstage_t     dprep_next;

    always_comb
    begin
        abs_a = sq_side.a[14] ? 15'(-sq_side.a) : 15'(sq_side.a);
        abs_b = sq_side.b[14] ? 15'(-sq_side.b) : 15'(sq_side.b);
        dprep_next.func   = sq_side.func;
        dprep_next.neg_a  = sq_side.a[14];
        dprep_next.neg_b  = sq_side.b[14];
        dprep_next.zero_a = (sq_side.a == 0);
        dprep_next.zero_b = (sq_side.b == 0);
        dprep_next.mag    = sq_mag;
        dprep_next.res_a  = sq_side.res_a;
        dprep_next.res_b  = sq_side.res_b;
        dprep_next.rem_a  = (DIV_W'(abs_a) << 13) + DIV_W'(sq_mag);
        dprep_next.rem_b  = (DIV_W'(abs_b) << 13) + DIV_W'(sq_mag);
        dprep_next.den    = DEN_W'(sq_mag) << 1;
        dprep_next.q_a    = '0;
        dprep_next.q_b    = '0;
    end

    logic    dv_reg [Q_W+1];
    dstage_t ds_reg [Q_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (en)
            dv_reg[0] <= sq_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ds_reg[0] <= dprep_next;
    end

    // restoring division, quotient MSB first
    for (genvar t = 0; t < Q_W; t++) begin : g_div
        localparam int J = Q_W - 1 - t;
        logic [DIV_W-1:0] dsh;
        dstage_t          ds_next;

        always_comb
        begin
            ds_next = ds_reg[t];
            dsh     = DIV_W'(ds_reg[t].den) << J;
            if (ds_reg[t].rem_a >= dsh)
            begin
                ds_next.rem_a  = ds_reg[t].rem_a - dsh;
                ds_next.q_a[J] = 1'b1;
            end
            if (ds_reg[t].rem_b >= dsh)
            begin
                ds_next.rem_b  = ds_reg[t].rem_b - dsh;
                ds_next.q_b[J] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[t+1] <= 1'b0;
            else if (en)
                dv_reg[t+1] <= dv_reg[t];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                ds_reg[t+1] <= ds_next;
        end
    end

    // ---------------- output: select, saturate, register
    dstage_t              dl;
    logic signed [RW-1:0] na, nb, mg, sel_a, sel_b;
    logic signed [CW-1:0] wa, wb, sa, sb;

    always_comb
    begin
        dl = ds_reg[Q_W];
        na = dl.zero_a ? '0 : (dl.neg_a ? -RW'(dl.q_a) : RW'(dl.q_a));
        nb = dl.zero_b ? '0 : (dl.neg_b ? -RW'(dl.q_b) : RW'(dl.q_b));
        mg = RW'(dl.mag);
        case (dl.func)
            FN_MAG:
            begin
                sel_a = mg;
                sel_b = '0;
            end
            FN_NORM:
            begin
                sel_a = na;
                sel_b = nb;
            end
            FN_C2P:
            begin
                sel_a = dl.res_a;
                sel_b = mg;
            end
            default:
            begin
                sel_a = dl.res_a;
                sel_b = dl.res_b;
            end
        endcase
        wa = CW'(sel_a);
        wb = CW'(sel_b);
        sa = (wa > SAT_HI) ? SAT_HI : ((wa < SAT_LO) ? SAT_LO : wa);
        sb = (wb > SAT_HI) ? SAT_HI : ((wb < SAT_LO) ? SAT_LO : wb);
    end

    logic               out_vld_reg;
    logic signed [15:0] out_a_reg;
    logic signed [15:0] out_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= dv_reg[Q_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_a_reg <= sa[15:0];
            out_b_reg <= sb[15:0];
        end
    end

    assign out_valid = out_vld_reg;
    assign out_a     = out_a_reg;
    assign out_b     = out_b_reg;

    // ---------------- checks
    // a stall must not drop a request sitting in the front stage
    `ASSERT_NEXT(a_front_hold, !en && s1_vld_reg, s1_vld_reg, "front request lost in stall")
    // rounded root of a 15-bit pair cannot pass sqrt(2^29)
    `ASSERT_IMPLY(a_mag_range, sq_vld, sq_mag <= 15'd23171, "magnitude out of range")
    // a normalized nonzero component never exceeds one
    `ASSERT_IMPLY(a_norm_range, dv_reg[Q_W] && ds_reg[Q_W].func == FN_NORM && !ds_reg[Q_W].zero_a,
                  ds_reg[Q_W].q_a <= 13'd4096, "normalize quotient above one")

endmodule
